/* src/alpha_blend_over_assert.svh */
// Assertion helpers for the compositing block.
// Each macro expects clk and rst_n in scope and is disabled while in reset.
`ifndef ALPHA_BLEND_OVER_ASSERT_SVH
`define ALPHA_BLEND_OVER_ASSERT_SVH

// Same-cycle implication
`define ABO_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ABO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/abo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package abo_pkg;

    // Channel geometry
    localparam int CH_W = 8;
    localparam int NCH  = 3;
    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // Weights, numerators and denominator of the general blend
    localparam int W_W   = 16;
    localparam int NUM_W = 24;
    localparam int DEN_W = 16;

    // Restoring divider: quotient width and bits resolved per stage
    localparam int Q_W        = 8;
    localparam int DIV_BPS    = 2;
    localparam int DIV_STAGES = Q_W / DIV_BPS;

    // floor(x / 255) for any 16-bit x is (x * 0x8081) >> 23
    localparam int PROD_W      = 32;
    localparam logic [DEN_W-1:0] RECIP_255 = 16'h8081;
    localparam int RECIP_SHIFT = 23;

    typedef struct packed {
        logic [CH_W-1:0] dst_red;
        logic [CH_W-1:0] dst_green;
        logic [CH_W-1:0] dst_blue;
        logic [CH_W-1:0] dst_alpha;
        logic [CH_W-1:0] src_red;
        logic [CH_W-1:0] src_green;
        logic [CH_W-1:0] src_blue;
        logic [CH_W-1:0] src_alpha;
    } pixel_in_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } pixel_out_t;

    // Data that rides beside the arithmetic
    typedef struct packed {
        logic            bypass;
        pixel_out_t      pass;
        logic [CH_W-1:0] mix_alpha;
    } side_t;

endpackage

`default_nettype wire

/* src/abo_div_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, DIV_BPS quotient bits per register stage.
// The quotient is known to fit in Q_W bits (num < den << Q_W).
module abo_div_lane import abo_pkg::*;
(
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quot
);

    logic [NUM_W-1:0] rem_reg [DIV_STAGES-1];
    logic [DEN_W-1:0] den_reg [DIV_STAGES-1];
    logic [Q_W-1:0]   q_reg   [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   q_in;
        logic [NUM_W-1:0] rem_next;
        logic [Q_W-1:0]   q_next;

        // Pick up the previous stage, or the operands at the head
        if (s == 0) begin : g_head
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end
        else begin : g_body
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign q_in   = q_reg[s-1];
        end

        // Resolve this stage's quotient bits, most significant first
        always_comb
        begin : c_step
            logic [NUM_W-1:0] trial;
            rem_next = rem_in;
            q_next   = q_in;
            for (int j = 0; j < DIV_BPS; j++)
            begin
                trial = NUM_W'(den_in) << (Q_W - 1 - s * DIV_BPS - j);
                if (rem_next >= trial)
                begin
                    rem_next = rem_next - trial;
                    q_next[Q_W - 1 - s * DIV_BPS - j] = 1'b1;
                end
            end
        end

        // Advance the quotient every cycle
        always_ff @(posedge clk)
        begin
            q_reg[s] <= q_next;
        end

        // Hold remainder and divisor for the stages still to come
        if (s < DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_in;
            end
        end
    end

    assign quot = q_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

/* src/alpha_blend_over.sv */
`timescale 1ns / 1ps
`default_nettype none

// Source-over-destination compositing of straight-alpha 8-bit RGBA pixels.
// Raise start with a pixel pair on pixel; busy never rises, so a pixel is
// taken on every clock that start is high. The blended pixel appears on
// result for exactly one cycle, marked by done, and must be captured at the
// edge that ends that cycle: there is no way to hold it. Sustained rate is
// one pixel per clock. The pixel passes through eight register stages, the
// first loaded at the edge that takes the pixel: three arithmetic stages
// (weights, weighted products, numerator sums with the alpha reciprocal
// multiply), a four-stage restoring divider resolving two quotient bits per
// stage for each colour lane, and the output register.
module alpha_blend_over import abo_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  pixel_in_t  pixel,
    output logic       busy,
    output logic       done,
    output pixel_out_t result
);

    `include "alpha_blend_over_assert.svh"

    localparam int PIPE_LAT = 4 + DIV_STAGES;

    logic                accept;
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] vld_next;

    // Stage 1: weights and bypass decision
    logic [W_W-1:0]   wsrc_reg, wsrc_next;
    logic [W_W-1:0]   wdst_reg, wdst_next;
    logic [CH_W-1:0]  sc_reg [NCH];
    logic [CH_W-1:0]  dc_reg [NCH];
    logic [CH_W-1:0]  sc_next [NCH];
    logic [CH_W-1:0]  dc_next [NCH];
    side_t            side1_reg, side1_next;

    // Stage 2: denominator and weighted products
    logic [DEN_W-1:0] den2_reg, den2_next;
    logic [NUM_W-1:0] prod_s_reg [NCH];
    logic [NUM_W-1:0] prod_d_reg [NCH];
    logic [NUM_W-1:0] prod_s_next [NCH];
    logic [NUM_W-1:0] prod_d_next [NCH];
    side_t            side2_reg;

    // Stage 3: numerators and blended alpha
    logic [DEN_W-1:0]  den3_reg;
    logic [NUM_W-1:0]  num3_reg [NCH];
    logic [NUM_W-1:0]  num3_next [NCH];
    logic [PROD_W-1:0] alpha_prod;
    side_t             side3_reg, side3_next;

    // Divider stages and output
    side_t            side_dly_reg [DIV_STAGES];
    logic [Q_W-1:0]   quot [NCH];
    pixel_out_t       result_reg, result_next;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Valid bits travel with the beat
    assign vld_next = {vld_reg[PIPE_LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: source weight sa*255, destination weight (255-sa)*da
    always_comb
    begin
        wsrc_next = (W_W'(pixel.src_alpha) << CH_W) - W_W'(pixel.src_alpha);
        wdst_next = W_W'(CH_MAX - pixel.src_alpha) * W_W'(pixel.dst_alpha);
        sc_next[0] = pixel.src_red;
        sc_next[1] = pixel.src_green;
        sc_next[2] = pixel.src_blue;
        dc_next[0] = pixel.dst_red;
        dc_next[1] = pixel.dst_green;
        dc_next[2] = pixel.dst_blue;

        side1_next.bypass = (pixel.src_alpha == '0) || (pixel.dst_alpha == '0) ||
                            (pixel.src_alpha == CH_MAX);
        side1_next.mix_alpha = '0;
        if (pixel.src_alpha == '0)
        begin
            side1_next.pass.out_red   = pixel.dst_red;
            side1_next.pass.out_green = pixel.dst_green;
            side1_next.pass.out_blue  = pixel.dst_blue;
            side1_next.pass.out_alpha = pixel.dst_alpha;
        end
        else
        begin
            side1_next.pass.out_red   = pixel.src_red;
            side1_next.pass.out_green = pixel.src_green;
            side1_next.pass.out_blue  = pixel.src_blue;
            side1_next.pass.out_alpha = pixel.src_alpha;
        end
    end

    // Stage 2: sum the weights, weight each channel
    always_comb
    begin
        den2_next = wsrc_reg + wdst_reg;
        for (int c = 0; c < NCH; c++)
        begin
            prod_s_next[c] = NUM_W'(wsrc_reg) * NUM_W'(sc_reg[c]);
            prod_d_next[c] = NUM_W'(wdst_reg) * NUM_W'(dc_reg[c]);
        end
    end

    // Stage 3: numerators, alpha as floor(den / 255)
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            num3_next[c] = prod_s_reg[c] + prod_d_reg[c];
        end
        alpha_prod = PROD_W'(den2_reg) * PROD_W'(RECIP_255);
        side3_next = side2_reg;
        side3_next.mix_alpha = CH_W'(alpha_prod >> RECIP_SHIFT);
    end

    // Arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        wsrc_reg  <= wsrc_next;
        wdst_reg  <= wdst_next;
        sc_reg    <= sc_next;
        dc_reg    <= dc_next;
        side1_reg <= side1_next;

        den2_reg   <= den2_next;
        prod_s_reg <= prod_s_next;
        prod_d_reg <= prod_d_next;
        side2_reg  <= side1_reg;

        den3_reg  <= den2_reg;
        num3_reg  <= num3_next;
        side3_reg <= side3_next;
    end

    // One divider lane per colour channel
    for (genvar c = 0; c < NCH; c++) begin : g_lane
        abo_div_lane u_div
        (
            .clk  (clk),
            .num  (num3_reg[c]),
            .den  (den3_reg),
            .quot (quot[c])
        );
    end

    // Delay the side data alongside the divider
    always_ff @(posedge clk)
    begin
        side_dly_reg[0] <= side3_reg;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            side_dly_reg[s] <= side_dly_reg[s-1];
        end
    end

    // Output: pass a pixel through or take the blend
    always_comb
    begin
        if (side_dly_reg[DIV_STAGES-1].bypass)
        begin
            result_next = side_dly_reg[DIV_STAGES-1].pass;
        end
        else
        begin
            result_next.out_red   = quot[0];
            result_next.out_green = quot[1];
            result_next.out_blue  = quot[2];
            result_next.out_alpha = side_dly_reg[DIV_STAGES-1].mix_alpha;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = vld_reg[PIPE_LAT-1];

    // Every done beat stems from a pixel that was taken at the head of the pipeline
    `ABO_ASSERT_IMPL(a_done_has_beat, done, $past(start && !busy, PIPE_LAT), "done without beat")

    // Over never makes a pixel more transparent than either input
    `ABO_ASSERT_IMPL(a_alpha_covers, done,
        (result.out_alpha >= $past(pixel.src_alpha, PIPE_LAT)) &&
        (result.out_alpha >= $past(pixel.dst_alpha, PIPE_LAT)), "alpha below inputs")

    // A transparent source leaves the destination untouched
    `ABO_ASSERT_IMPL(a_clear_src_passes, done && ($past(pixel.src_alpha, PIPE_LAT) == '0),
        (result.out_red == $past(pixel.dst_red, PIPE_LAT)) &&
        (result.out_green == $past(pixel.dst_green, PIPE_LAT)) &&
        (result.out_blue == $past(pixel.dst_blue, PIPE_LAT)) &&
        (result.out_alpha == $past(pixel.dst_alpha, PIPE_LAT)), "destination not passed")

endmodule

`default_nettype wire
